[design/spq_pkg.sv]
`default_nettype none

package spq_pkg;

    // Queue geometry.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 5;

    // Operation codes on the command input.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Signed less-or-equal on raw key patterns.
    function automatic logic key_le(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        key_le = ($signed(a) <= $signed(b));
    endfunction

endpackage

`default_nettype wire

[design/spq_ram.sv]
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/sorted_array_priority_queue.sv]
// A rejected insert, a delete on an empty queue, or an insert into an empty queue
// gives its result in the cycle after start; other inserts and deletes walk the
// stored keys. The key array sits in one RAM with one write and one registered read
// port, walked one slot per cycle. One operation is in flight at a time; busy is high
// until its result strobe. Results cannot be stalled.
// Reset (synchronous, active low) empties the queue; the key RAM is not cleared.
`default_nettype none

module sorted_array_priority_queue
    import spq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_cmd,
    input  wire logic signed [KEY_W-1:0] i_key_in,
    output logic                         o_done,
    output logic signed [KEY_W-1:0]      o_key_out,
    output logic [1:0]                   o_status,
    output logic [ENTRY_W-1:0]           o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_DEL_HEAD,
        S_DEL_SHIFT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [KEY_W-1:0]   r_key;
    logic               r_done;
    logic [KEY_W-1:0]   r_key_out;
    t_status            r_status;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [KEY_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [KEY_W-1:0]   ram_rdata;

    logic               accept;
    logic               ins_stop;
    logic               del_last;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign ins_stop = key_le(ram_rdata, r_key);
    assign del_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    spq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // RAM port control. Reads and writes in one cycle never touch the same slot.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_INSERT) begin
                        if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_wdata = i_key_in;
                        end else if (r_count < CNT_W'(CAPACITY)) begin
                            ram_re    = 1'b1;
                            ram_raddr = IDX_W'(r_count - CNT_W'(1));
                        end
                    end else if (r_count != '0) begin
                        ram_re = 1'b1;
                    end
                end
            end
            S_INS: begin
                // Either drop the new key above this one, or move this key up a slot.
                ram_we    = 1'b1;
                ram_waddr = r_idx + IDX_W'(1);
                if (ins_stop) begin
                    ram_wdata = r_key;
                end else begin
                    ram_wdata = ram_rdata;
                    if (r_idx != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx - IDX_W'(1);
                    end
                end
            end
            S_INS_LAST: begin
                ram_we    = 1'b1;
                ram_wdata = r_key;
            end
            S_DEL_HEAD: begin
                if (r_count > CNT_W'(1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(1);
                end
            end
            S_DEL_SHIFT: begin
                // Move each key down a slot.
                ram_we    = 1'b1;
                ram_waddr = r_idx - IDX_W'(1);
                ram_wdata = ram_rdata;
                if (!del_last) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer state, stored count and registered result.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key <= i_key_in;
                        if (i_cmd == CMD_INSERT) begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                r_done    <= 1'b1;
                                r_status  <= ST_FULL;
                                r_key_out <= '0;
                            end else if (r_count == '0) begin
                                r_done    <= 1'b1;
                                r_status  <= ST_DONE;
                                r_key_out <= '0;
                                r_count   <= CNT_W'(1);
                            end else begin
                                r_idx   <= IDX_W'(r_count - CNT_W'(1));
                                r_state <= S_INS;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_done    <= 1'b1;
                                r_status  <= ST_EMPTY;
                                r_key_out <= '0;
                            end else begin
                                r_state <= S_DEL_HEAD;
                            end
                        end
                    end
                end
                S_INS: begin
                    if (ins_stop) begin
                        r_done    <= 1'b1;
                        r_status  <= ST_DONE;
                        r_key_out <= '0;
                        r_count   <= r_count + CNT_W'(1);
                        r_state   <= S_IDLE;
                    end else if (r_idx == '0) begin
                        r_state <= S_INS_LAST;
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
                S_INS_LAST: begin
                    r_done    <= 1'b1;
                    r_status  <= ST_DONE;
                    r_key_out <= '0;
                    r_count   <= r_count + CNT_W'(1);
                    r_state   <= S_IDLE;
                end
                S_DEL_HEAD: begin
                    // Slot zero holds the smallest key.
                    r_key_out <= ram_rdata;
                    if (r_count == CNT_W'(1)) begin
                        r_done   <= 1'b1;
                        r_status <= ST_DONE;
                        r_count  <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= IDX_W'(1);
                        r_state <= S_DEL_SHIFT;
                    end
                end
                S_DEL_SHIFT: begin
                    if (del_last) begin
                        r_done   <= 1'b1;
                        r_status <= ST_DONE;
                        r_count  <= r_count - CNT_W'(1);
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_key_out     = r_key_out;
    assign o_status      = r_status;
    assign o_entry_count = ENTRY_W'(r_count);

endmodule

`default_nettype wire

[tb/spq_checker.sv]
module spq_checker
    import spq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire logic                    i_cmd,
    input  wire logic signed [KEY_W-1:0] i_key_in,
    input  wire logic                    o_done,
    input  wire logic signed [KEY_W-1:0] o_key_out,
    input  wire logic [1:0]              o_status,
    input  wire logic [ENTRY_W-1:0]      o_entry_count,
    output int                           err_total,
    output int                           outstanding
);

    // One predicted outcome of a queue operation.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [1:0]              status;
        logic [ENTRY_W-1:0]      count;
    } t_op_outcome;

    // Shadow copy of the queue contents, ascending from slot zero.
    // The counters are two-state and start at zero.
    logic signed [KEY_W-1:0] model_keys [CAPACITY];
    int                      model_count;

    t_op_outcome outcome_q [$];
    int          errors;

    // Apply one operation to the shadow queue and return what the block should report.
    function automatic t_op_outcome apply_queue_op(input logic cmd,
                                                   input logic signed [KEY_W-1:0] key);
        t_op_outcome res;
        int          pos;
        int          i;
        res.key    = '0;
        res.status = ST_DONE;
        if (cmd == CMD_INSERT) begin
            if (model_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // Equal keys keep arrival order, so skip past all of them.
                pos = 0;
                while (pos < model_count && model_keys[pos] <= key)
                    pos++;
                for (i = model_count; i > pos; i--)
                    model_keys[i] = model_keys[i-1];
                model_keys[pos] = key;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.key = model_keys[0];
                for (i = 1; i < model_count; i++)
                    model_keys[i-1] = model_keys[i];
                model_count--;
            end
        end
        res.count = model_count[ENTRY_W-1:0];
        return res;
    endfunction

    // Retire the strobed result first, then queue the prediction for a new transaction.
    always @(posedge i_clk) begin
        t_op_outcome want;
        if (!i_rst_n) begin
            model_count = 0;
            outcome_q.delete();
        end else begin
            if (o_done === 1'b1) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result: key_out %0d status %0d entry_count %0d",
                           o_key_out, o_status, o_entry_count);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_key_out !== want.key) begin
                        $error("key_out mismatch: expected %0d, actual %0d",
                               want.key, o_key_out);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        errors++;
                    end
                    if (o_entry_count !== want.count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.count, o_entry_count);
                        errors++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                outcome_q.push_back(apply_queue_op(i_cmd, i_key_in));
        end
        err_total   <= errors;
        outstanding <= outcome_q.size();
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import spq_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 950;
    localparam int DRAIN_CYCLES  = 40;

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    start    = 1'b0;
    logic                    i_cmd    = CMD_INSERT;
    logic signed [KEY_W-1:0] i_key_in = '0;
    logic                    busy;
    logic                    o_done;
    logic signed [KEY_W-1:0] o_key_out;
    logic [1:0]              o_status;
    logic [ENTRY_W-1:0]      o_entry_count;
    int                      err_total;
    int                      outstanding;
    int                      quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    sorted_array_priority_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_key_in      (i_key_in),
        .o_done        (o_done),
        .o_key_out     (o_key_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    spq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_key_in      (i_key_in),
        .o_done        (o_done),
        .o_key_out     (o_key_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .err_total     (err_total),
        .outstanding   (outstanding)
    );

    // Watchdog: give up when no transaction and no result has been seen for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("sorted_array_priority_queue verification failed");
            $finish;
        end
    end

    // Present one operation, optionally after a random gap, and hold it until taken.
    task automatic send_op(input logic cmd, input logic signed [KEY_W-1:0] key,
                           input bit idle_ok);
        int gap;
        gap = idle_ok ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_cmd    <= cmd;
        i_key_in <= key;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Random key: full range, a narrow band that makes duplicates, or an extreme.
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 3))
            0: k = $urandom_range(0, 6) - 3;
            1: begin
                case ($urandom_range(0, 5))
                    0: k = 32'sh8000_0000;
                    1: k = 32'sh7FFF_FFFF;
                    2: k = 32'sh8000_0001;
                    3: k = 32'sh7FFF_FFFE;
                    4: k = '0;
                    default: k = -1;
                endcase
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    initial begin
        int   sent;
        int   burst_len;
        int   insert_pct;
        bit   idle_ok;
        logic cmd;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: delete on an empty queue, extremes, duplicate keys, fill to capacity,
        // insert when full, then drain a few.
        send_op(CMD_DELETE, 32'shFFFF_FFFF, 1'b1);
        send_op(CMD_INSERT, 32'sh8000_0000, 1'b1);
        send_op(CMD_INSERT, 32'sh7FFF_FFFF, 1'b1);
        send_op(CMD_INSERT, 32'sd0, 1'b1);
        send_op(CMD_INSERT, -32'sd1, 1'b1);
        send_op(CMD_INSERT, 32'sd7, 1'b1);
        send_op(CMD_INSERT, 32'sd7, 1'b0);
        send_op(CMD_INSERT, -32'sd7, 1'b0);
        send_op(CMD_INSERT, 32'sd7, 1'b1);
        send_op(CMD_INSERT, 32'sh8000_0000, 1'b1);
        send_op(CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
        send_op(CMD_INSERT, 32'sd1, 1'b1);
        send_op(CMD_INSERT, -32'sd1, 1'b1);
        send_op(CMD_INSERT, 32'sd3, 1'b0);
        send_op(CMD_INSERT, 32'sd100, 1'b1);
        send_op(CMD_INSERT, -32'sd100, 1'b1);
        send_op(CMD_INSERT, 32'sd0, 1'b1);
        send_op(CMD_INSERT, 32'sd42, 1'b1);
        send_op(CMD_DELETE, 32'sh5A5A_A5A5, 1'b0);
        send_op(CMD_DELETE, 32'sd0, 1'b1);
        send_op(CMD_DELETE, 32'shA5A5_5A5A, 1'b1);

        // Random bursts lean toward filling, draining, or churning the queue.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            idle_ok = ($urandom_range(0, 3) != 0);
            repeat (burst_len) begin
                cmd = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_DELETE;
                send_op(cmd, (cmd == CMD_INSERT) ? pick_key() : $urandom, idle_ok);
                sent++;
            end
        end
        start <= 1'b0;

        // Wait for the last result, then give the block time to show stray strobes.
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_total == 0 && outstanding == 0)
            $display("sorted_array_priority_queue verification clean");
        else
            $display("sorted_array_priority_queue verification failed");
        $finish;
    end

endmodule

[sim.f]
design/spq_pkg.sv
design/spq_ram.sv
design/sorted_array_priority_queue.sv
tb/spq_checker.sv
tb/tb_top.sv
